### hdl/grk_pkg.sv
// Shared types for the record grouping block: word structs for both channels,
// the datapath opcode and the command and status groups between controller and datapath.
// No dependencies.
`default_nettype none
package grk_pkg;

    typedef struct packed {
        logic [7:0]  record_key;
        logic [31:0] record_payload;
        logic        last_record;
    } rec_in_t;

    typedef struct packed {
        logic [7:0]  out_key;
        logic [31:0] out_payload;
        logic        out_last;
    } rec_out_t;

    typedef enum logic [3:0] {
        OP_IDLE,
        OP_CLEAR,
        OP_LOAD,
        OP_INC,
        OP_OFS,
        OP_FRD,
        OP_FCHK,
        OP_T,
        OP_PT,
        OP_SW1,
        OP_SW2,
        OP_ERD,
        OP_ELAT,
        OP_EWAIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic accept;
        logic close;
        logic ofs_done;
        logic f_zero;
        logic f_last;
        logic t_zero;
        logic out_taken;
        logic emit_done;
    } dp_stat_t;

endpackage
`default_nettype wire

### hdl/group_records_by_key.sv
// Record grouping block: collects a set of key/payload words, then emits them grouped
// by key in ascending key order, the final word marked out_last.
// Input channel s_valid/s_ready/s_data, result channel m_valid/m_ready/m_data.
// A set ends on a word with last_record set, or on the word that fills the store
// (RECORDS words). Keys use the low KEY_BITS bits, payloads the low PAYLOAD_BITS bits.
// Phases, K = 2**KEY_BITS key slots:
//   load: store write, then count table read-modify-write for the word's key;
//   offset scan over all K keys; swap loop: a key probe reads the count and offset
//   tables, a swap reads the word and its target slot, then writes both slots;
//   emit: store read, output latch, wait for m_ready; the count table is cleared after
//   the set and after reset, with s_ready low. Count table, store: one read port each.
// While the receiver stalls, the word on m_data holds and nothing else advances;
// s_ready stays low from the closing word until the clear pass ends.
// Uses grk_pkg, grk_ctrl, grk_datapath, grk_ram.
`default_nettype none
module group_records_by_key #(
    parameter int RECORDS      = 64,
    parameter int KEY_BITS     = 8,
    parameter int PAYLOAD_BITS = 32
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire grk_pkg::rec_in_t s_data,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output grk_pkg::rec_out_t     m_data
);

    grk_pkg::dp_cmd_t  cmd;
    grk_pkg::dp_stat_t st;

    grk_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .st      (st),
        .cmd     (cmd),
        .s_ready (s_ready)
    );

    grk_datapath #(
        .RECORDS      (RECORDS),
        .KEY_BITS     (KEY_BITS),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .st      (st),
        .s_valid (s_valid),
        .s_data  (s_data),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .m_data  (m_data)
    );

endmodule
`default_nettype wire

### hdl/grk_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`default_nettype none
module grk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

### hdl/grk_datapath.sv
// Datapath of the grouping block: record store, per-key count and offset tables,
// counters and the output register. Uses grk_pkg and grk_ram.
`default_nettype none
module grk_datapath #(
    parameter int RECORDS      = 64,
    parameter int KEY_BITS     = 8,
    parameter int PAYLOAD_BITS = 32
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire grk_pkg::dp_cmd_t  cmd,
    output grk_pkg::dp_stat_t      st,
    input  wire logic              s_valid,
    input  wire grk_pkg::rec_in_t  s_data,
    input  wire logic              m_ready,
    output logic                   m_valid,
    output grk_pkg::rec_out_t      m_data
);

    localparam int KEY_SPACE = 1 << KEY_BITS;
    localparam int AW = (RECORDS > 1) ? $clog2(RECORDS) : 1;
    localparam int CW = $clog2(RECORDS + 1);
    localparam int SW = KEY_BITS + PAYLOAD_BITS;

    // store
    logic          st_we;
    logic [AW-1:0] st_waddr, st_raddr;
    logic [SW-1:0] st_wdata, st_rd;
    // count table
    logic                cn_we;
    logic [KEY_BITS-1:0] cn_waddr, cn_raddr;
    logic [CW-1:0]       cn_wdata, cn_rd;
    // offset table
    logic                of_we;
    logic [KEY_BITS-1:0] of_waddr, of_raddr;
    logic [AW-1:0]       of_wdata, of_rd;

    logic [CW-1:0]       loaded_reg, loaded_next;
    logic [CW-1:0]       i_reg, i_next;
    logic [CW-1:0]       off_reg, off_next;
    logic [KEY_BITS:0]   sweep_reg, sweep_next;
    logic [KEY_BITS-1:0] f_reg, f_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [KEY_BITS-1:0] t_reg, t_next;
    logic [AW-1:0]       pf_reg, pf_next, pt_reg, pt_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [SW-1:0]       a_reg, a_next;
    logic                m_valid_reg, m_valid_next;
    grk_pkg::rec_out_t   out_reg, out_next;

    logic [KEY_BITS-1:0] in_key;
    logic [KEY_BITS-1:0] sweep_prev;
    logic                accept;

    assign in_key     = KEY_BITS'(s_data.record_key);
    assign sweep_prev = sweep_reg[KEY_BITS-1:0] - KEY_BITS'(1);
    assign accept     = (cmd.op == grk_pkg::OP_LOAD) && s_valid;

    grk_ram #(.WIDTH(SW), .DEPTH(RECORDS)) u_store (
        .clk(aclk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
        .raddr(st_raddr), .rdata(st_rd)
    );
    grk_ram #(.WIDTH(CW), .DEPTH(KEY_SPACE)) u_counts (
        .clk(aclk), .we(cn_we), .waddr(cn_waddr), .wdata(cn_wdata),
        .raddr(cn_raddr), .rdata(cn_rd)
    );
    grk_ram #(.WIDTH(AW), .DEPTH(KEY_SPACE)) u_offsets (
        .clk(aclk), .we(of_we), .waddr(of_waddr), .wdata(of_wdata),
        .raddr(of_raddr), .rdata(of_rd)
    );

    always_comb begin
        st_we = 1'b0;  st_waddr = pf_reg;  st_wdata = st_rd;  st_raddr = i_reg[AW-1:0];
        cn_we = 1'b0;  cn_waddr = t_reg;   cn_wdata = '0;     cn_raddr = f_reg;
        of_we = 1'b0;  of_waddr = t_reg;   of_wdata = '0;     of_raddr = f_reg;
        loaded_next = loaded_reg;  i_next = i_reg;  off_next = off_reg;
        sweep_next = sweep_reg;    f_next = f_reg;  key_next = key_reg;
        t_next = t_reg;  pf_next = pf_reg;  pt_next = pt_reg;  cnt_next = cnt_reg;
        a_next = a_reg;  m_valid_next = m_valid_reg;  out_next = out_reg;
        st = '0;
        st.accept     = accept;
        st.close      = s_data.last_record || (loaded_reg == CW'(RECORDS - 1));
        st.clear_done = (sweep_reg == (KEY_BITS + 1)'(KEY_SPACE - 1));
        st.ofs_done   = (sweep_reg == (KEY_BITS + 1)'(KEY_SPACE));
        st.f_zero     = (cn_rd == '0);
        st.f_last     = &f_reg;
        st.t_zero     = (cn_rd == '0);
        st.out_taken  = m_ready && m_valid_reg;
        st.emit_done  = out_reg.out_last;

        unique case (cmd.op)
            grk_pkg::OP_CLEAR: begin
                cn_we = 1'b1;
                cn_waddr = sweep_reg[KEY_BITS-1:0];
                cn_wdata = '0;
                sweep_next = st.clear_done ? '0 : sweep_reg + 1'b1;
                loaded_next = '0;
                i_next = '0;
                off_next = '0;
                f_next = '0;
            end
            grk_pkg::OP_LOAD: begin
                cn_raddr = in_key;
                if (accept) begin
                    st_we = 1'b1;
                    st_waddr = loaded_reg[AW-1:0];
                    st_wdata = {in_key, PAYLOAD_BITS'(s_data.record_payload)};
                    key_next = in_key;
                    loaded_next = loaded_reg + 1'b1;
                end
            end
            grk_pkg::OP_INC: begin
                cn_we = 1'b1;
                cn_waddr = key_reg;
                cn_wdata = cn_rd + 1'b1;
            end
            grk_pkg::OP_OFS: begin
                // read key k, place key k-1 from the registered read data of the previous scan step
                cn_raddr = sweep_reg[KEY_BITS-1:0];
                if (sweep_reg != '0 && cn_rd != '0) begin
                    of_we = 1'b1;
                    of_waddr = sweep_prev;
                    of_wdata = off_reg[AW-1:0];
                    off_next = off_reg + cn_rd;
                end
                sweep_next = st.ofs_done ? '0 : sweep_reg + 1'b1;
            end
            grk_pkg::OP_FRD: begin
                cn_raddr = f_reg;
                of_raddr = f_reg;
            end
            grk_pkg::OP_FCHK: begin
                st_raddr = of_rd;
                if (cn_rd == '0) begin
                    f_next = f_reg + 1'b1;
                end else begin
                    pf_next = of_rd;
                end
            end
            grk_pkg::OP_T: begin
                a_next = st_rd;
                t_next = st_rd[SW-1 -: KEY_BITS];
                cn_raddr = st_rd[SW-1 -: KEY_BITS];
                of_raddr = st_rd[SW-1 -: KEY_BITS];
            end
            grk_pkg::OP_PT: begin
                st_raddr = of_rd;
                pt_next = of_rd;
                cnt_next = cn_rd;
            end
            grk_pkg::OP_SW1: begin
                // word from the target slot goes to the source slot
                st_we = 1'b1;
                st_waddr = pf_reg;
                st_wdata = st_rd;
                cn_we = 1'b1;
                cn_waddr = t_reg;
                cn_wdata = cnt_reg - 1'b1;
                of_we = 1'b1;
                of_waddr = t_reg;
                of_wdata = pt_reg + 1'b1;
            end
            grk_pkg::OP_SW2: begin
                st_we = 1'b1;
                st_waddr = pt_reg;
                st_wdata = a_reg;
            end
            grk_pkg::OP_ERD: begin
                st_raddr = i_reg[AW-1:0];
            end
            grk_pkg::OP_ELAT: begin
                out_next.out_key = 8'(st_rd[SW-1 -: KEY_BITS]);
                out_next.out_payload = 32'(st_rd[PAYLOAD_BITS-1:0]);
                out_next.out_last = (i_reg == loaded_reg - CW'(1));
                m_valid_next = 1'b1;
            end
            grk_pkg::OP_EWAIT: begin
                if (st.out_taken) begin
                    m_valid_next = 1'b0;
                    i_next = i_reg + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            loaded_reg  <= '0;
            i_reg       <= '0;
            off_reg     <= '0;
            sweep_reg   <= '0;
            f_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            loaded_reg  <= loaded_next;
            i_reg       <= i_next;
            off_reg     <= off_next;
            sweep_reg   <= sweep_next;
            f_reg       <= f_next;
            m_valid_reg <= m_valid_next;
        end
        key_reg <= key_next;
        t_reg   <= t_next;
        pf_reg  <= pf_next;
        pt_reg  <= pt_next;
        cnt_reg <= cnt_next;
        a_reg   <= a_next;
        out_reg <= out_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        loaded_reg <= CW'(RECORDS))
        else $error("store fill count past capacity");
    assert property (@(posedge aclk) disable iff (!aresetn)
        off_reg <= loaded_reg)
        else $error("group offsets run past the loaded records");
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == grk_pkg::OP_SW1 |-> cnt_reg != '0)
        else $error("swap on a key with no records left");
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == grk_pkg::OP_LOAD |-> !m_valid_reg)
        else $error("loading while a result word is pending");

endmodule
`default_nettype wire

### hdl/grk_ctrl.sv
// Sequencer of the grouping block: load, offset scan, swap loop, emit and table clear.
// Uses grk_pkg; drives the datapath through dp_cmd_t and reads dp_stat_t.
`default_nettype none
module grk_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire grk_pkg::dp_stat_t st,
    output grk_pkg::dp_cmd_t       cmd,
    output logic                   s_ready
);

    typedef enum logic [3:0] {
        ST_CLEAR, ST_LOAD, ST_INC, ST_OFS, ST_FRD, ST_FCHK, ST_T, ST_PT,
        ST_SW1, ST_SW2, ST_ERD, ST_ELAT, ST_EWAIT
    } state_t;

    state_t state_reg, state_next;
    logic   close_reg, close_next;

    always_comb begin
        state_next = state_reg;
        close_next = close_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.op = grk_pkg::OP_CLEAR;
                if (st.clear_done) state_next = ST_LOAD;
            end
            ST_LOAD: begin
                cmd.op = grk_pkg::OP_LOAD;
                if (st.accept) begin
                    close_next = st.close;
                    state_next = ST_INC;
                end
            end
            ST_INC: begin
                cmd.op = grk_pkg::OP_INC;
                state_next = close_reg ? ST_OFS : ST_LOAD;
            end
            ST_OFS: begin
                cmd.op = grk_pkg::OP_OFS;
                if (st.ofs_done) state_next = ST_FRD;
            end
            ST_FRD: begin
                cmd.op = grk_pkg::OP_FRD;
                state_next = ST_FCHK;
            end
            ST_FCHK: begin
                cmd.op = grk_pkg::OP_FCHK;
                if (!st.f_zero) state_next = ST_T;
                else if (st.f_last) state_next = ST_ERD;
                else state_next = ST_FRD;
            end
            ST_T: begin
                cmd.op = grk_pkg::OP_T;
                state_next = ST_PT;
            end
            ST_PT: begin
                cmd.op = grk_pkg::OP_PT;
                state_next = st.t_zero ? ST_ERD : ST_SW1;
            end
            ST_SW1: begin
                cmd.op = grk_pkg::OP_SW1;
                state_next = ST_SW2;
            end
            ST_SW2: begin
                cmd.op = grk_pkg::OP_SW2;
                state_next = ST_FRD;
            end
            ST_ERD: begin
                cmd.op = grk_pkg::OP_ERD;
                state_next = ST_ELAT;
            end
            ST_ELAT: begin
                cmd.op = grk_pkg::OP_ELAT;
                state_next = ST_EWAIT;
            end
            ST_EWAIT: begin
                cmd.op = grk_pkg::OP_EWAIT;
                if (st.out_taken) state_next = st.emit_done ? ST_CLEAR : ST_ERD;
            end
            default: begin
                cmd.op = grk_pkg::OP_IDLE;
                state_next = ST_CLEAR;
            end
        endcase
    end

    assign s_ready = (state_reg == ST_LOAD);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            close_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            close_reg <= close_next;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_INC && close_reg |=> state_reg == ST_OFS)
        else $error("closing word did not start the offset scan");
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SW1 |=> state_reg == ST_SW2)
        else $error("swap left half done");
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_EWAIT && !st.out_taken |=> state_reg == ST_EWAIT)
        else $error("result word dropped while stalled");

endmodule
`default_nettype wire
